// File: hw/rtl/kl_pkg.sv
// Shared types, character codes and keyword tracking functions for the keyword lexer.
package kl_pkg;

  // Token kinds carried on the result channel.
  typedef enum logic [3:0] {
    KindPlus   = 4'd0,
    KindMinus  = 4'd1,
    KindSemi   = 4'd2,
    KindAssign = 4'd3,
    KindInt    = 4'd4,
    KindIdent  = 4'd5,
    KindWhile  = 4'd6,
    KindFor    = 4'd7,
    KindEof    = 4'd8,
    KindBad    = 4'd9
  } kind_e;

  // Keyword prefix tracker codes.
  typedef enum logic [3:0] {
    TrkNone  = 4'd0,
    TrkW     = 4'd1,
    TrkWh    = 4'd2,
    TrkWhi   = 4'd3,
    TrkWhil  = 4'd4,
    TrkWhile = 4'd5,
    TrkF     = 4'd6,
    TrkFo    = 4'd7,
    TrkFor   = 4'd8
  } track_e;

  // Character codes the lexer recognizes.
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChAssign = 8'h3D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChW      = 8'h77;
  localparam logic [7:0] ChH      = 8'h68;
  localparam logic [7:0] ChI      = 8'h69;
  localparam logic [7:0] ChL      = 8'h6C;
  localparam logic [7:0] ChE      = 8'h65;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChO      = 8'h6F;
  localparam logic [7:0] ChR      = 8'h72;

  localparam logic [15:0] LineMax = 16'hFFFF;

  // One result item.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] line;
    logic [7:0]  bad;
    logic        last;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // Tracker code for the first letter of a word.
  function automatic track_e track_start(input logic [7:0] c);
    if (c == ChW) return TrkW;
    if (c == ChF) return TrkF;
    return TrkNone;
  endfunction

  // Advance the tracker by one more word character.
  function automatic track_e track_next(input track_e t, input logic [7:0] c);
    track_e n;
    n = TrkNone;
    case (t)
      TrkW:    n = (c == ChH) ? TrkWh   : TrkNone;
      TrkWh:   n = (c == ChI) ? TrkWhi  : TrkNone;
      TrkWhi:  n = (c == ChL) ? TrkWhil : TrkNone;
      TrkWhil: n = (c == ChE) ? TrkWhile : TrkNone;
      TrkF:    n = (c == ChO) ? TrkFo   : TrkNone;
      TrkFo:   n = (c == ChR) ? TrkFor  : TrkNone;
      default: n = TrkNone;
    endcase
    return n;
  endfunction

endpackage

// File: hw/rtl/keyword_lexer.sv
// Streaming tokenizer top level: character classification, scan state and result queue.
//
// Input channel (s_axis): one source character per beat in tdata[7:0]. A beat with
// tlast high marks end of source; its character is ignored. End of source flushes
// any open word, emits an EOF token and returns the scanner to its reset state.
// Output channel (m_axis): one token per beat. tuser holds the token kind, tdata holds
// start offset, length, line number and the offending byte of a bad character.
// tlast is high on the final token caused by one input beat.
// An input beat gives zero, one or two tokens; a word token leaves with the
// character that ends it.
// A token is written to the result queue when its input beat is accepted and is offered
// on m_axis from the queue head. Throughput: one input beat per cycle. The classifier and
// scan state update in the cycle of acceptance and write a four-entry result queue;
// s_axis_tready is high while the queue has room for two tokens. The output port drains
// one token per cycle, so inputs that give two tokens each fill the queue and are then
// held off. When the receiver stalls, tokens wait in the queue and the input is held
// off once fewer than two entries are free.
// Reset clears the scan state, the position (to zero), the line count (to one)
// and empties the queue.
module keyword_lexer #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input beat.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // end_of_source
  // Output beat.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [15:0] token_start, [31:16] token_length,
                                      // [47:32] token_line, [55:48] bad_char
  output logic [3:0]  m_axis_tuser,   // [3:0] token_kind
  output logic        m_axis_tlast    // last_of_run
);

  localparam int unsigned PosW = POSITION_BITS;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    ModeIdle = 2'd0,
    ModeNum  = 2'd1,
    ModeWord = 2'd2
  } mode_e;

  // Saturate a position value to the 16-bit output fields.
  function automatic logic [15:0] sat16(input logic [PosW-1:0] v);
    logic [32:0] ext;
    ext = 33'(v);
    return (ext > 33'h0FFFF) ? 16'hFFFF : ext[15:0];
  endfunction

  // Scan state.
  mode_e             mode_q, mode_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW-1:0]   start_q, start_d;
  logic [15:0]       line_q, line_d;
  kl_pkg::track_e    track_q, track_d;

  // Result queue.
  kl_pkg::result_t   queue_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;

  logic              in_fire, out_fire;
  logic [7:0]        ch;
  logic              eos;
  logic              flush_vld, tok_vld;
  kl_pkg::result_t   flush_res, tok_res;
  logic [1:0]        n_push;

  assign ch       = s_axis_tdata;
  assign eos      = s_axis_tlast;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = (cnt_q <= QCntW'(QDepth - 2));

  // Classify the character and compute the tokens and the next scan state.
  always_comb begin
    logic word_cont;
    logic num_cont;
    mode_d    = mode_q;
    pos_d     = (pos_q < PosMax) ? pos_q + 1'b1 : pos_q;
    start_d   = start_q;
    line_d    = line_q;
    track_d   = track_q;
    flush_vld = 1'b0;
    tok_vld   = 1'b0;

    // Word token for the open number or word, ending at the current position.
    flush_res.kind   = kl_pkg::KindIdent;
    if (mode_q == ModeNum) begin
      flush_res.kind = kl_pkg::KindInt;
    end else if (track_q == kl_pkg::TrkWhile) begin
      flush_res.kind = kl_pkg::KindWhile;
    end else if (track_q == kl_pkg::TrkFor) begin
      flush_res.kind = kl_pkg::KindFor;
    end
    flush_res.start  = sat16(start_q);
    flush_res.length = sat16(pos_q - start_q);
    flush_res.line   = line_q;
    flush_res.bad    = 8'd0;
    flush_res.last   = 1'b0;

    // Single-character token at the current position.
    tok_res.kind   = kl_pkg::KindBad;
    tok_res.start  = sat16(pos_q);
    tok_res.length = 16'd1;
    tok_res.line   = line_q;
    tok_res.bad    = 8'd0;
    tok_res.last   = 1'b1;

    num_cont  = (mode_q == ModeNum) && kl_pkg::is_digit(ch);
    word_cont = (mode_q == ModeWord) && (kl_pkg::is_alpha(ch) || kl_pkg::is_digit(ch));

    if (eos) begin
      flush_vld      = (mode_q == ModeNum) || (mode_q == ModeWord);
      tok_vld        = 1'b1;
      tok_res.kind   = kl_pkg::KindEof;
      tok_res.length = 16'd0;
      mode_d         = ModeIdle;
      pos_d          = '0;
      start_d        = '0;
      line_d         = 16'd1;
      track_d        = kl_pkg::TrkNone;
    end else if (num_cont) begin
      // Number continues.
    end else if (word_cont) begin
      track_d = kl_pkg::track_next(track_q, ch);
    end else begin
      flush_vld = (mode_q == ModeNum) || (mode_q == ModeWord);
      mode_d    = ModeIdle;
      track_d   = kl_pkg::TrkNone;
      case (ch)
        kl_pkg::ChPlus: begin
          tok_vld      = 1'b1;
          tok_res.kind = kl_pkg::KindPlus;
        end
        kl_pkg::ChMinus: begin
          tok_vld      = 1'b1;
          tok_res.kind = kl_pkg::KindMinus;
        end
        kl_pkg::ChSemi: begin
          tok_vld      = 1'b1;
          tok_res.kind = kl_pkg::KindSemi;
        end
        kl_pkg::ChAssign: begin
          tok_vld      = 1'b1;
          tok_res.kind = kl_pkg::KindAssign;
        end
        kl_pkg::ChSpace, kl_pkg::ChTab, kl_pkg::ChCr: begin
        end
        kl_pkg::ChLf: begin
          if (line_q < kl_pkg::LineMax) begin
            line_d = line_q + 16'd1;
          end
        end
        default: begin
          if (kl_pkg::is_digit(ch)) begin
            mode_d  = ModeNum;
            start_d = pos_q;
          end else if (kl_pkg::is_alpha(ch)) begin
            mode_d  = ModeWord;
            start_d = pos_q;
            track_d = kl_pkg::track_start(ch);
          end else begin
            tok_vld      = 1'b1;
            tok_res.kind = kl_pkg::KindBad;
            tok_res.bad  = ch;
          end
        end
      endcase
    end

    // The word token is last only when no character token follows it.
    flush_res.last = !tok_vld;
    n_push = in_fire ? (2'(flush_vld) + 2'(tok_vld)) : 2'd0;
  end

  // Scan state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      pos_q   <= '0;
      start_q <= '0;
      line_q  <= 16'd1;
      track_q <= kl_pkg::TrkNone;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      line_q  <= line_d;
      track_q <= track_d;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(n_push);
      rd_ptr_q <= rd_ptr_q + QPtrW'(out_fire);
      cnt_q    <= cnt_q + QCntW'(n_push) - QCntW'(out_fire);
    end
  end

  // Queue payload: the word token first, then the character token.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (flush_vld) begin
        queue_q[wr_ptr_q] <= flush_res;
      end
      if (tok_vld) begin
        queue_q[wr_ptr_q + QPtrW'(flush_vld)] <= tok_res;
      end
    end
  end

  // Output beat from the queue head.
  kl_pkg::result_t head;
  assign head          = queue_q[rd_ptr_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tuser  = head.kind;
  assign m_axis_tdata  = {head.bad, head.line, head.length, head.start};
  assign m_axis_tlast  = head.last;

`ifndef NO_ASSERTIONS
  // The queue never holds more entries than it has.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  // Two tokens from one beat only when a word was open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push == 2'd2) |-> (mode_q != ModeIdle))
    else $error("two tokens without an open word");

  // End of source returns the scanner to its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && eos) |=> (mode_q == ModeIdle && pos_q == '0 && line_q == 16'd1))
    else $error("scan state not cleared after end of source");

  // An accepted end of source always queues a token.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && eos) |=> (cnt_q != '0))
    else $error("end of source produced no token");
`endif

endmodule

// File: tb/kl_checker.sv
// Token predictor and scoreboard that watches both stream channels of the keyword lexer.
module kl_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,    // [7:0] char_code
  input  logic        s_axis_tlast_i,    // end_of_source
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [55:0] m_axis_tdata_i,    // [15:0] token_start, [31:16] token_length,
                                         // [47:32] token_line, [55:48] bad_char
  input  logic [3:0]  m_axis_tuser_i,    // [3:0] token_kind
  input  logic        m_axis_tlast_i,    // last_of_run
  output int          mismatch_count_o,
  output int          tokens_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] OffsetMax = 16'hFFFF;
  localparam int          ReportLimit = 10;

  typedef enum logic [1:0] {
    ScanIdle   = 2'd0,
    ScanNumber = 2'd1,
    ScanWord   = 2'd2
  } scan_e;

  // Scanner state as the predictor sees it.
  scan_e            scan = ScanIdle;
  logic [15:0]      next_offset = '0;
  logic [15:0]      word_begin = '0;
  logic [15:0]      line_no = 16'd1;
  kl_pkg::track_e   kw_track = kl_pkg::TrkNone;

  // Tokens predicted but not yet seen on the output channel.
  kl_pkg::result_t tokens_due[$];
  kl_pkg::result_t held_token;
  logic            token_held = 1'b0;
  int              mismatches = 0;

  function automatic logic is_num_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // Append one predicted token at the tail of the expected list.
  function automatic void queue_token(input kl_pkg::result_t t);
    tokens_due = {tokens_due, t};
  endfunction

  // Extend the keyword prefix by one word character; any miss drops the match for good.
  function automatic kl_pkg::track_e advance_track(input kl_pkg::track_e t,
                                                   input logic [7:0] c);
    kl_pkg::track_e n;
    n = kl_pkg::TrkNone;
    if (t == kl_pkg::TrkW && c == kl_pkg::ChH) n = kl_pkg::TrkWh;
    else if (t == kl_pkg::TrkWh && c == kl_pkg::ChI) n = kl_pkg::TrkWhi;
    else if (t == kl_pkg::TrkWhi && c == kl_pkg::ChL) n = kl_pkg::TrkWhil;
    else if (t == kl_pkg::TrkWhil && c == kl_pkg::ChE) n = kl_pkg::TrkWhile;
    else if (t == kl_pkg::TrkF && c == kl_pkg::ChO) n = kl_pkg::TrkFo;
    else if (t == kl_pkg::TrkFo && c == kl_pkg::ChR) n = kl_pkg::TrkFor;
    return n;
  endfunction

  // The newest token of a beat is held back so that its last flag can be set.
  function automatic void add_token(input kl_pkg::kind_e k, input logic [15:0] start,
                                    input logic [15:0] len, input logic [7:0] bad);
    if (token_held) queue_token(held_token);
    held_token.kind   = k;
    held_token.start  = start;
    held_token.length = len;
    held_token.line   = line_no;
    held_token.bad    = bad;
    held_token.last   = 1'b0;
    token_held = 1'b1;
  endfunction

  // Emit the open number or word, if any, and go back to idle.
  function automatic void close_word();
    logic [15:0] len;
    len = next_offset - word_begin;
    if (scan == ScanNumber) begin
      add_token(kl_pkg::KindInt, word_begin, len, 8'd0);
    end else if (scan == ScanWord) begin
      if (kw_track == kl_pkg::TrkWhile) add_token(kl_pkg::KindWhile, word_begin, len, 8'd0);
      else if (kw_track == kl_pkg::TrkFor) add_token(kl_pkg::KindFor, word_begin, len, 8'd0);
      else add_token(kl_pkg::KindIdent, word_begin, len, 8'd0);
    end
    scan = ScanIdle;
    kw_track = kl_pkg::TrkNone;
  endfunction

  function automatic void clear_scanner();
    scan = ScanIdle;
    next_offset = '0;
    word_begin = '0;
    line_no = 16'd1;
    kw_track = kl_pkg::TrkNone;
  endfunction

  // Work out the tokens that one accepted input beat gives.
  function automatic void lex_beat(input logic [7:0] c, input logic eos);
    if (eos) begin
      close_word();
      add_token(kl_pkg::KindEof, next_offset, 16'd0, 8'd0);
      clear_scanner();
    end else begin
      if (scan == ScanNumber && is_num_char(c)) begin
        // The number grows by one digit.
      end else if (scan == ScanWord && (is_letter(c) || is_num_char(c))) begin
        kw_track = advance_track(kw_track, c);
      end else begin
        close_word();
        case (c)
          kl_pkg::ChPlus:   add_token(kl_pkg::KindPlus, next_offset, 16'd1, 8'd0);
          kl_pkg::ChMinus:  add_token(kl_pkg::KindMinus, next_offset, 16'd1, 8'd0);
          kl_pkg::ChSemi:   add_token(kl_pkg::KindSemi, next_offset, 16'd1, 8'd0);
          kl_pkg::ChAssign: add_token(kl_pkg::KindAssign, next_offset, 16'd1, 8'd0);
          kl_pkg::ChSpace, kl_pkg::ChTab, kl_pkg::ChCr: ;
          kl_pkg::ChLf: begin
            if (line_no != kl_pkg::LineMax) line_no = line_no + 16'd1;
          end
          default: begin
            if (is_num_char(c)) begin
              scan = ScanNumber;
              word_begin = next_offset;
            end else if (is_letter(c)) begin
              scan = ScanWord;
              word_begin = next_offset;
              kw_track = (c == kl_pkg::ChW) ? kl_pkg::TrkW :
                         (c == kl_pkg::ChF) ? kl_pkg::TrkF : kl_pkg::TrkNone;
            end else begin
              add_token(kl_pkg::KindBad, next_offset, 16'd1, c);
            end
          end
        endcase
      end
      if (next_offset != OffsetMax) next_offset = next_offset + 16'd1;
    end
    if (token_held) begin
      held_token.last = 1'b1;
      queue_token(held_token);
      token_held = 1'b0;
    end
  endfunction

  // Compare output beats first, then predict from the input beat of the same edge.
  always @(posedge clk_i) begin
    kl_pkg::result_t want;
    kl_pkg::result_t got;
    if (!rst_ni) begin
      clear_scanner();
      tokens_due.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.kind   = kl_pkg::kind_e'(m_axis_tuser_i);
        got.start  = m_axis_tdata_i[15:0];
        got.length = m_axis_tdata_i[31:16];
        got.line   = m_axis_tdata_i[47:32];
        got.bad    = m_axis_tdata_i[55:48];
        got.last   = m_axis_tlast_i;
        if (tokens_due.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display({"%0t: token beat with none predicted: kind %0d start %0d",
                      " len %0d line %0d"}, $realtime, got.kind, got.start,
                     got.length, got.line);
          end
        end else begin
          want = tokens_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display({"%0t: token mismatch: expected kind %0d start %0d len %0d line %0d",
                        " bad %0d last %0d"}, $realtime, want.kind, want.start,
                       want.length, want.line, want.bad, want.last);
              $display({"%0t:                   actual kind %0d start %0d len %0d line %0d",
                        " bad %0d last %0d"}, $realtime, got.kind, got.start,
                       got.length, got.line, got.bad, got.last);
            end
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        lex_beat(s_axis_tdata_i, s_axis_tlast_i);
      end
    end
    mismatch_count_o <= mismatches;
    tokens_pending_o <= tokens_due.size();
  end

endmodule

// File: tb/tb_keyword_lexer.sv
// Top-level testbench for the keyword lexer: clock, reset, character stimulus and verdict.
module tb_keyword_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget  = 550;
  localparam int StallLimit  = 1000;
  localparam int DrainCycles = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;
  logic        s_last = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [55:0] m_data;
  logic [3:0]  m_user;
  logic        m_last;

  int send_idle_pct = 22;
  int recv_idle_pct = 54;
  int sent_items = 0;
  int quiet_cycles;
  int mismatch_count;
  int tokens_pending;

  always #5ns clk_i = ~clk_i;

  keyword_lexer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last)
  );

  kl_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_valid),
    .s_axis_tready_i  (s_ready),
    .s_axis_tdata_i   (s_data),
    .s_axis_tlast_i   (s_last),
    .m_axis_tvalid_i  (m_valid),
    .m_axis_tready_i  (m_ready),
    .m_axis_tdata_i   (m_data),
    .m_axis_tuser_i   (m_user),
    .m_axis_tlast_i   (m_last),
    .mismatch_count_o (mismatch_count),
    .tokens_pending_o (tokens_pending)
  );

  // Receiver stalls at random according to the current phase.
  always @(posedge clk_i) begin
    m_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
  end

  // Offer one character beat, with random sender gaps, and wait for its acceptance.
  task automatic send_beat(input logic [7:0] c, input logic eos);
    if (int'($urandom_range(99)) < send_idle_pct) begin
      s_valid <= 1'b0;
      do @(posedge clk_i); while (int'($urandom_range(99)) < send_idle_pct);
    end
    s_valid <= 1'b1;
    s_data  <= c;
    s_last  <= eos;
    do @(posedge clk_i); while (!s_ready);
    sent_items++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_beat(txt[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1) == 0) return 8'("a" + $urandom_range(25));
    return 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_word_char();
    if ($urandom_range(3) == 0) return 8'("0" + $urandom_range(9));
    return rand_letter();
  endfunction

  // One lexical unit: mostly words, operators and whitespace, some noise bytes and end of source.
  task automatic send_random_token();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 18) begin
      n = $urandom_range(1, 6);
      repeat (n) send_beat(8'("0" + $urandom_range(9)), 1'b0);
    end else if (pick < 36) begin
      send_beat(rand_letter(), 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) send_beat(rand_word_char(), 1'b0);
    end else if (pick < 46) begin
      if ($urandom_range(1) == 0) send_text("while");
      else send_text("for");
    end else if (pick < 54) begin
      // Near misses of the keywords.
      case ($urandom_range(4))
        0: send_text("whil");
        1: send_text("fo");
        2: send_text("whiles");
        3: send_text("fork");
        default: send_text("wHile");
      endcase
    end else if (pick < 70) begin
      case ($urandom_range(3))
        0: send_beat(kl_pkg::ChPlus, 1'b0);
        1: send_beat(kl_pkg::ChMinus, 1'b0);
        2: send_beat(kl_pkg::ChSemi, 1'b0);
        default: send_beat(kl_pkg::ChAssign, 1'b0);
      endcase
    end else if (pick < 84) begin
      case ($urandom_range(3))
        0: send_beat(kl_pkg::ChSpace, 1'b0);
        1: send_beat(kl_pkg::ChTab, 1'b0);
        2: send_beat(kl_pkg::ChCr, 1'b0);
        default: send_beat(kl_pkg::ChLf, 1'b0);
      endcase
    end else if (pick < 96) begin
      send_beat(8'($urandom_range(255)), 1'b0);
    end else begin
      send_beat(8'($urandom_range(255)), 1'b1);
    end
  endtask

  task automatic run_random(input int items);
    int stop_at;
    stop_at = sent_items + items;
    while (sent_items < stop_at) send_random_token();
  endtask

  // Hold the input off until every predicted token has left the block.
  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (tokens_pending != 0) @(posedge clk_i);
  endtask

  // Ends the run when neither channel moves a beat for too long.
  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("** keyword_lexer: FAILED **");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: keywords, every operator, a word ending in a digit, all whitespace,
    // extreme bytes, a bad printable byte, end with an open word and end with none.
    send_text("while;for=9-+ W1");
    send_beat(kl_pkg::ChTab, 1'b0);
    send_beat(kl_pkg::ChCr, 1'b0);
    send_beat(kl_pkg::ChLf, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_text("~x");
    send_beat(8'($urandom_range(255)), 1'b1);
    send_beat(8'h00, 1'b1);
    wait_drained();

    run_random(ItemTarget / 3);
    wait_drained();

    send_idle_pct = 54;
    recv_idle_pct = 22;
    run_random(ItemTarget / 3);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(ItemTarget - 2 * (ItemTarget / 3));
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && tokens_pending == 0) begin
      $display("** keyword_lexer: PASSED **");
    end else begin
      $display("** keyword_lexer: FAILED **");
    end
    $finish;
  end

endmodule
